[src/mbps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int PatWordW    = 64;
  localparam int NumPatWords = 4;
  localparam int PatBitsW    = PatWordW * NumPatWords;
  localparam int MaskW       = 32;
  localparam int LenW        = 6;
  localparam int CountW      = 12;
  localparam int OffsetW     = 32;
  localparam int CfgIndexW   = 3;

  typedef enum logic [CfgIndexW-1:0] {
    REG_PAT_LOW    = 3'd0,
    REG_PAT_SECOND = 3'd1,
    REG_PAT_THIRD  = 3'd2,
    REG_PAT_HIGH   = 3'd3,
    REG_MASK       = 3'd4,
    REG_LENGTH     = 3'd5,
    REG_CAP        = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    KIND_MATCH   = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_t;

  typedef struct packed {
    result_kind_t         kind;
    logic [OffsetW-1:0]   offset;
    logic [CountW-1:0]    count;
    logic                 run_end;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } result_pair_t;

endpackage

[src/mbps_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_scan
// Byte window, parallel masked compare and per-buffer counters. Builds the
// zero, one or two results caused by the word stepped in.
// ----------------------------------------------------------------------------
module mbps_scan
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN = 32,
  parameter int MAX_HITS    = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic [PatBitsW-1:0] pattern,
  input  logic [MaskW-1:0]    pattern_mask,
  input  logic [LenW-1:0]     pattern_length,
  input  logic [CountW-1:0]   match_cap,
  output result_pair_t        results
);

  localparam int FillW = $clog2(MAX_PATTERN + 1);
  localparam logic [FillW-1:0] FillMax  = FillW'(MAX_PATTERN);
  localparam logic [LenW-1:0]  MaxLen   = LenW'(MAX_PATTERN);
  localparam logic [16:0]      HitLimit = 17'(MAX_HITS);

  logic [7:0]           window [MAX_PATTERN];
  logic [7:0]           win_now [MAX_PATTERN];
  logic [FillW-1:0]     fill;
  logic [FillW-1:0]     fill_now;
  logic [OffsetW-1:0]   position;
  logic [CountW-1:0]    hit_count;
  logic [CountW-1:0]    hit_inc;
  logic [LenW-1:0]      len;
  logic [LenW-1:0]      shift;
  logic [MAX_PATTERN*8-1:0] pat_rev;
  logic [MAX_PATTERN*8-1:0] pat_al;
  logic [MAX_PATTERN-1:0]   mask_rev;
  logic [MAX_PATTERN-1:0]   mask_al;
  logic [MAX_PATTERN-1:0]   miss;
  logic                 under_cap;
  logic                 hit;
  logic [OffsetW-1:0]   offset;

  // pattern reversed so that age a lines up with pattern byte len-1-a
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_rev
    assign pat_rev[k*8 +: 8] = pattern[(MAX_PATTERN-1-k)*8 +: 8];
    assign mask_rev[k]       = pattern_mask[MAX_PATTERN-1-k];
  end

  always_comb begin
    win_now[0] = data_byte;
    for (int a = 1; a < MAX_PATTERN; a++) begin
      win_now[a] = window[a-1];
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      len = LenW'(1);
    end else if (pattern_length > MaxLen) begin
      len = MaxLen;
    end else begin
      len = pattern_length;
    end
  end

  assign shift   = MaxLen - len;
  assign pat_al  = pat_rev >> {shift, 3'b000};
  assign mask_al = mask_rev >> shift;

  always_comb begin
    for (int a = 0; a < MAX_PATTERN; a++) begin
      miss[a] = mask_al[a] && (win_now[a] != pat_al[a*8 +: 8]);
    end
  end

  assign fill_now  = (fill == FillMax) ? fill : fill + FillW'(1);
  assign under_cap = (hit_count < match_cap) && (17'(hit_count) < HitLimit);
  assign hit       = (LenW'(fill_now) >= len) && under_cap && !(|miss);
  assign hit_inc   = hit_count + CountW'(1);
  assign offset    = position - OffsetW'(len - LenW'(1));

  always_comb begin
    results = '0;
    if (step) begin
      if (hit) begin
        results.res0 = '{kind: KIND_MATCH, offset: offset, count: hit_inc,
                         run_end: !last_byte};
        if (last_byte) begin
          results.num  = 2'd2;
          results.res1 = '{kind: KIND_SUMMARY, offset: '0, count: hit_inc,
                           run_end: 1'b1};
        end else begin
          results.num = 2'd1;
        end
      end else if (last_byte) begin
        results.num  = 2'd1;
        results.res0 = '{kind: KIND_SUMMARY, offset: '0, count: hit_count,
                         run_end: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int a = 0; a < MAX_PATTERN; a++) begin
        window[a] <= win_now[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      position  <= '0;
      hit_count <= '0;
    end else if (step) begin
      if (last_byte) begin
        fill      <= '0;
        position  <= '0;
        hit_count <= '0;
      end else begin
        fill <= fill_now;
        if (position != '1) begin
          position <= position + OffsetW'(1);
        end
        if (hit) begin
          hit_count <= hit_inc;
        end
      end
    end
  end

endmodule

[src/mbps_resq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_resq
// Four-entry result queue; takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module mbps_resq
  import mbps_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  result_pair_t push,
  output logic         room,
  output logic         out_valid,
  input  logic         out_ready,
  output result_t      out_result
);

  result_t    q [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] cnt;
  logic       pop;

  assign out_valid  = (cnt != 3'd0);
  assign out_result = q[rp];
  assign pop        = out_valid && out_ready;
  assign room       = (cnt <= 3'd2);

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      q[wp] <= push.res0;
    end
    if (push.num == 2'd2) begin
      q[wp + 2'd1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + push.num;
      rp  <= rp + 2'(pop);
      cnt <= cnt + 3'(push.num) - 3'(pop);
    end
  end

endmodule

[src/masked_byte_pattern_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan
// Wildcard byte pattern scanner: reports match offsets and a per-buffer
// summary on a result stream.
// ----------------------------------------------------------------------------
// Takes one buffer byte per cycle while the result queue has room. A byte is
// registered at the input, then compared against the full pattern window and
// its results are written to a four-entry result queue, from which they are
// presented on the result stream. Input stays ready while the queue has two
// free entries; a last byte that both matches and closes the buffer yields two
// results, handed out one at a time. Configuration writes are always ready and
// must only be issued while no byte is in flight.
module masked_byte_pattern_scan
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN = 32,
  parameter int MAX_HITS    = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // data_byte
  input  logic                 s_axis_tlast,   // last_byte
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [47:0]          m_axis_tdata,   // match_offset, match_count, pad
  output logic                 m_axis_tuser,   // result_kind
  output logic                 m_axis_tlast,   // run_end
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [PatWordW-1:0]  cfg_data
);

  logic [PatBitsW-1:0] pattern;
  logic [MaskW-1:0]    pattern_mask;
  logic [LenW-1:0]     pattern_length;
  logic [CountW-1:0]   match_cap;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       room;
  logic       step;

  result_pair_t results;
  result_t      out_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= '0;
      pattern_mask   <= '0;
      pattern_length <= LenW'(1);
      match_cap      <= CountW'(2048);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PAT_LOW:    pattern[0*PatWordW +: PatWordW] <= cfg_data;
        REG_PAT_SECOND: pattern[1*PatWordW +: PatWordW] <= cfg_data;
        REG_PAT_THIRD:  pattern[2*PatWordW +: PatWordW] <= cfg_data;
        REG_PAT_HIGH:   pattern[3*PatWordW +: PatWordW] <= cfg_data;
        REG_MASK:       pattern_mask   <= cfg_data[MaskW-1:0];
        REG_LENGTH:     pattern_length <= cfg_data[LenW-1:0];
        REG_CAP:        match_cap      <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign step          = in_valid && room;
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  mbps_scan #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_HITS    (MAX_HITS)
  ) u_scan (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .data_byte      (in_byte),
    .last_byte      (in_last),
    .pattern        (pattern),
    .pattern_mask   (pattern_mask),
    .pattern_length (pattern_length),
    .match_cap      (match_cap),
    .results        (results)
  );

  mbps_resq u_resq (
    .clk        (clk),
    .rst        (rst),
    .push       (results),
    .room       (room),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (out_result)
  );

  assign m_axis_tdata = {4'b0000, out_result.count, out_result.offset};
  assign m_axis_tuser = out_result.kind;
  assign m_axis_tlast = out_result.run_end;

endmodule

[src/mbps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_checker
// Port-level checks for the scanner, bound to the top level.
// ----------------------------------------------------------------------------
module mbps_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // no result and input open right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("result word present or input closed after reset");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("result word changed while stalled");

  // summary closes the run and carries no offset
  a_summary_form: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tlast && (m_axis_tdata[31:0] == 32'd0)))
    else $error("malformed summary word");

  // a match report always counts itself
  a_match_counted: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[43:32] != 12'd0))
    else $error("match report with zero count");

  // pad bits of the result word stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[47:44] == 4'd0))
    else $error("nonzero pad in result word");

endmodule

bind masked_byte_pattern_scan mbps_checker u_mbps_checker (.*);

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the masked byte pattern scanner. Buffers are
// streamed in with random bursts and gaps while the result side stalls on
// its own pattern. A software copy of the scanner predicts every match
// report and end-of-buffer summary, and each received word is compared
// field by field with the oldest prediction. Pattern, mask, length and cap
// are reprogrammed between phases, only while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_top;
  import mbps_pkg::*;

  localparam int MAX_PATTERN = 32;
  localparam int MAX_HITS    = 2048;
  localparam int LIMIT       = 1500000;
  localparam int SETTLE      = 8;

  class scan_tracker;
    logic [63:0]         pat_word [4];
    logic [MaskW-1:0]    mask;
    logic [LenW-1:0]     len_reg;
    logic [CountW-1:0]   cap_reg;
    logic [7:0]          window [MAX_PATTERN];
    int unsigned         fill;
    logic [OffsetW-1:0]  pos;
    logic [CountW-1:0]   hits;
    result_t             expected_reports [$];
    int                  errors;

    function new();
      foreach (pat_word[i]) pat_word[i] = '0;
      mask    = '0;
      len_reg = 6'd1;
      cap_reg = 12'd2048;
      errors  = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      foreach (window[i]) window[i] = 8'h00;
      fill = 0;
      pos  = '0;
      hits = '0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [63:0] v);
      case (idx)
        REG_PAT_LOW:    pat_word[0] = v;
        REG_PAT_SECOND: pat_word[1] = v;
        REG_PAT_THIRD:  pat_word[2] = v;
        REG_PAT_HIGH:   pat_word[3] = v;
        REG_MASK:       mask = v[MaskW-1:0];
        REG_LENGTH:     len_reg = v[LenW-1:0];
        REG_CAP:        cap_reg = v[CountW-1:0];
        default: ;
      endcase
    endfunction

    function void take_word(logic [7:0] d, logic last);
      int unsigned        len;
      int unsigned        cap;
      int                 j;
      logic [OffsetW-1:0] idx;
      bit                 hit;
      result_t            r;
      len = len_reg;
      if (len < 1) len = 1;
      if (len > MAX_PATTERN) len = MAX_PATTERN;
      cap = cap_reg;
      if (cap > MAX_HITS) cap = MAX_HITS;
      idx = pos;
      for (j = MAX_PATTERN - 1; j > 0; j--) window[j] = window[j-1];
      window[0] = d;
      if (fill < MAX_PATTERN) fill++;
      if (pos != 32'hFFFF_FFFF) pos++;
      if (fill >= len && hits < cap) begin
        hit = 1'b1;
        for (j = 0; j < len; j++) begin
          if (mask[j] && window[len-1-j] != pat_word[j>>3][(j & 7)*8 +: 8]) hit = 1'b0;
        end
        if (hit) begin
          hits++;
          r.kind    = KIND_MATCH;
          r.offset  = idx - (len - 1);
          r.count   = hits;
          r.run_end = !last;
          expected_reports = {expected_reports, r};
        end
      end
      if (last) begin
        r.kind    = KIND_SUMMARY;
        r.offset  = '0;
        r.count   = hits;
        r.run_end = 1'b1;
        expected_reports = {expected_reports, r};
        clear_scan();
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result kind=%0d off=%0h cnt=%0d end=%0d",
                   got.kind, got.offset, got.count, got.run_end);
        return;
      end
      exp = expected_reports.pop_front();
      if (got.kind !== exp.kind || got.offset !== exp.offset ||
          got.count !== exp.count || got.run_end !== exp.run_end) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp kind=%0d off=%0h cnt=%0d end=%0d, got kind=%0d off=%0h cnt=%0d end=%0d",
                   exp.kind, exp.offset, exp.count, exp.run_end,
                   got.kind, got.offset, got.count, got.run_end);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;   // data_byte
  logic                 s_axis_tlast;   // last_byte
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [47:0]          m_axis_tdata;   // match_offset, match_count, pad
  logic                 m_axis_tuser;   // result_kind
  logic                 m_axis_tlast;   // run_end
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index;
  logic [PatWordW-1:0]  cfg_data;

  scan_tracker  scan;
  int           cycle_count;
  int           burst_left;
  int           stall_tick;
  int           stall_mode;
  int           stall_run;
  logic [63:0]  cur_words [4];
  logic [31:0]  cur_mask;
  int unsigned  cur_len;

  masked_byte_pattern_scan #(
    .MAX_PATTERN(MAX_PATTERN),
    .MAX_HITS   (MAX_HITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind    = result_kind_t'(m_axis_tuser);
      got.offset  = m_axis_tdata[31:0];
      got.count   = m_axis_tdata[43:32];
      got.run_end = m_axis_tlast;
      scan.check_result(got);
    end
  end

  // result-side stall pattern
  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready = 1'b1;
      1: m_axis_tready = ($urandom_range(0, 3) != 0);
      2: m_axis_tready = (stall_tick % 5) < 2;
      default: begin
        if (stall_run == 0) begin
          stall_run     = $urandom_range(1, 20);
          m_axis_tready = ~m_axis_tready;
        end else begin
          stall_run--;
          m_axis_tready = m_axis_tready;
        end
      end
    endcase
  end

  task automatic write_reg(cfg_reg_t idx, logic [63:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    scan.set_reg(idx, v);
  endtask

  task automatic apply_config(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                              logic [63:0] w3, logic [31:0] m, logic [5:0] len,
                              logic [11:0] cap);
    write_reg(REG_PAT_LOW, w0);
    write_reg(REG_PAT_SECOND, w1);
    write_reg(REG_PAT_THIRD, w2);
    write_reg(REG_PAT_HIGH, w3);
    write_reg(REG_MASK, {32'h0, m});
    write_reg(REG_LENGTH, {58'h0, len});
    write_reg(REG_CAP, {52'h0, cap});
    @(negedge clk);
    cfg_valid = 1'b0;
    cur_words[0] = w0;
    cur_words[1] = w1;
    cur_words[2] = w2;
    cur_words[3] = w3;
    cur_mask = m;
    cur_len  = (len < 1) ? 1 : (len > MAX_PATTERN) ? MAX_PATTERN : len;
  endtask

  task automatic send_word(logic [7:0] d, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = d;
    s_axis_tlast  = last;
    do @(posedge clk); while (!s_axis_tready);
    scan.take_word(d, last);
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (scan.expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] pat_at(int unsigned j);
    return cur_words[j>>3][(j & 7)*8 +: 8];
  endfunction

  task automatic random_buffers(int target);
    int          sent;
    int          buf_len;
    int          sel;
    int unsigned j;
    logic [7:0]  fill_q [$];
    sent = 0;
    while (sent < target) begin
      buf_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 60);
      fill_q.delete();
      while (fill_q.size() < buf_len) begin
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
          for (j = 0; j < cur_len; j++)
            fill_q = {fill_q, (cur_mask[j] ? pat_at(j) : 8'($urandom_range(0, 255)))};
        end else if (sel < 60) begin
          fill_q = {fill_q, pat_at($urandom_range(0, cur_len - 1))};
        end else begin
          fill_q = {fill_q, 8'($urandom_range(0, 255))};
        end
      end
      for (int k = 0; k < buf_len; k++) send_word(fill_q[k], k == buf_len - 1);
      sent += buf_len;
      if ($urandom_range(0, 9) == 0) drain();
    end
    drain();
  endtask

  initial begin
    logic [63:0] w [4];
    logic [31:0] m;
    logic [5:0]  len;
    logic [11:0] cap;
    clk           = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_PAT_LOW;
    cfg_data      = '0;
    cycle_count   = 0;
    burst_left    = 0;
    stall_tick    = 0;
    stall_mode    = 0;
    stall_run     = 0;
    scan          = new();
    foreach (cur_words[i]) cur_words[i] = '0;
    cur_mask = '0;
    cur_len  = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: every word matches, last word gives report then summary
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    drain();

    // zero length clamps to one, unused mask bits ignored, cap above max
    apply_config(64'h0000_0000_0000_00A5, '0, '0, '0, 32'hFFFF_FFFF, 6'd0, 12'd4095);
    send_word(8'hA5, 1'b0);
    send_word(8'h5A, 1'b0);
    send_word(8'hA5, 1'b1);
    drain();

    // middle byte wildcard; short buffer; match on the last word
    apply_config(64'h0000_0000_0033_2211, '0, '0, '0, 32'hFFFF_FFF5, 6'd3, 12'd2048);
    send_word(8'h11, 1'b1);
    send_word(8'h11, 1'b0);
    send_word(8'h99, 1'b0);
    send_word(8'h33, 1'b0);
    send_word(8'h11, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h33, 1'b1);
    drain();

    // cap reached after one report
    write_reg(REG_CAP, 64'd1);
    @(negedge clk);
    cfg_valid = 1'b0;
    for (int k = 0; k < 6; k++) send_word(8'h11 * (8'(k % 3) + 8'd1), k == 5);
    drain();

    for (int p = 0; p < 10; p++) begin
      foreach (w[i]) w[i] = {$urandom, $urandom};
      m   = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
      len = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 32));
      cap = ($urandom_range(0, 1) == 0) ? 12'd2048 : 12'($urandom_range(0, 4095));
      case (p)
        0: begin
          m   = 32'hFFFF_FFFF;
          len = 6'd32;
          cap = 12'd4095;
        end
        1: begin
          m   = 32'h0;
          len = 6'd63;
          cap = 12'd0;
        end
        2: begin
          foreach (w[i]) w[i] = 64'hFFFF_FFFF_FFFF_FFFF;
          len = 6'd1;
        end
        3: cap = 12'($urandom_range(1, 5));
        4: begin
          foreach (w[i]) w[i] = 64'h0;
          len = 6'($urandom_range(2, 8));
        end
        default: ;
      endcase
      apply_config(w[0], w[1], w[2], w[3], m, len, cap);
      random_buffers(200);
    end

    if (scan.errors == 0 && scan.expected_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
